>>> hw/rtl/rk4_ode_step_unit_macros.svh
// Assertion macros for the RK4 step unit checker.
// No dependencies; included by the checker file only.
`ifndef RK4_ODE_STEP_UNIT_MACROS_SVH
`define RK4_ODE_STEP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RK4_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rk4 step unit check failed");

// Next-cycle implication, disabled while reset is high.
`define RK4_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rk4 step unit check failed");

`endif

>>> hw/rtl/rk4_pkg.sv
// Shared types, constants and microcode program for the RK4 step unit.
// No dependencies; used by rk4_ode_step_unit and rk4_chk.
package rk4_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 24;
  localparam int CNT_WIDTH   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = DATA_WIDTH;

  typedef logic signed [DATA_WIDTH-1:0] fix_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;

  localparam fix_t FIX_MAX = fix_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam fix_t FIX_MIN = fix_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
  localparam fix_t FIX_ONE = fix_t'(1 << FRAC_BITS);

  localparam fix_t                 X_START_RST    = fix_t'(0);
  localparam fix_t                 Y_START_RST    = fix_t'(16777216);
  localparam fix_t                 STEP_SIZE_RST  = fix_t'(1677722);
  localparam logic [CNT_WIDTH-1:0] STEP_COUNT_RST = CNT_WIDTH'(10);

  // Rounded product magnitude and its saturation limits.
  localparam int MAG_W = 2 * DATA_WIDTH - FRAC_BITS + 1;
  localparam logic [MAG_W-1:0] MAG_LIM_NEG = MAG_W'(1) << (DATA_WIDTH - 1);
  localparam logic [MAG_W-1:0] MAG_LIM_POS = MAG_LIM_NEG - MAG_W'(1);

  // Divide by six as a multiply by ceil(2^(DW+2)/6) and a shift.
  localparam int   DIV6_SHIFT = DATA_WIDTH + 2;
  localparam mag_t DIV6_RECIP = mag_t'(((65'd1 << DIV6_SHIFT) + 65'd5) / 65'd6);
  localparam int   DIV6_Q_W   = 2 * DATA_WIDTH - DIV6_SHIFT;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_START    = 2'd0,
    REG_Y_START    = 2'd1,
    REG_STEP_SIZE  = 2'd2,
    REG_STEP_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_H, SRC_ONE, SRC_XM, SRC_XB, SRC_T, SRC_U, SRC_K, SRC_S, SRC_V
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_X, DST_Y, DST_XM, DST_XB, DST_T, DST_U, DST_K, DST_S, DST_V
  } dst_t;

  typedef enum logic [2:0] {
    ALU_NOP, ALU_ADD, ALU_HALF, ALU_MULQ, ALU_DIV6
  } alu_op_t;

  typedef enum logic [1:0] {
    MUL_NONE, MUL_PROD, MUL_DIV6
  } mul_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_IF_DONE, JMP_FINISH
  } jmp_t;

  typedef enum logic [0:0] {
    SEQ_IDLE, SEQ_RUN
  } seq_state_t;

  localparam int UCODE_LEN = 43;
  localparam int UPC_W     = $clog2(UCODE_LEN);
  localparam logic [UPC_W-1:0] UPC_FIN = UPC_W'(UCODE_LEN - 1);

  typedef struct packed {
    mul_op_t           mul_op;
    src_t              mul_a;
    src_t              mul_b;
    alu_op_t           alu_op;
    src_t              alu_a;
    src_t              alu_b;
    dst_t              dst;
    jmp_t              jmp;
    logic [UPC_W-1:0]  target;
    logic              cnt_inc;
  } ucode_t;

  // All working registers seen by the operand muxes.
  typedef struct packed {
    fix_t x, y, h, xm, xb, t, u, k, s, v;
  } bank_t;

  function automatic mag_t mag_of(input fix_t v);
    mag_t vu;
    vu = mag_t'(v);
    return vu[DATA_WIDTH-1] ? (~vu + mag_t'(1)) : vu;
  endfunction

  function automatic fix_t neg_if(input logic neg, input mag_t m);
    return neg ? fix_t'(~m + mag_t'(1)) : fix_t'(m);
  endfunction

  function automatic fix_t pick(input bank_t b, input src_t sel);
    fix_t r;
    case (sel)
      SRC_X:   r = b.x;
      SRC_Y:   r = b.y;
      SRC_H:   r = b.h;
      SRC_ONE: r = FIX_ONE;
      SRC_XM:  r = b.xm;
      SRC_XB:  r = b.xb;
      SRC_T:   r = b.t;
      SRC_U:   r = b.u;
      SRC_K:   r = b.k;
      SRC_S:   r = b.s;
      SRC_V:   r = b.v;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic ucode_t uword(input mul_op_t mo, input src_t ma, input src_t mb,
                                   input alu_op_t ao, input src_t aa, input src_t ab,
                                   input dst_t d);
    ucode_t w;
    w.mul_op  = mo;
    w.mul_a   = ma;
    w.mul_b   = mb;
    w.alu_op  = ao;
    w.alu_a   = aa;
    w.alu_b   = ab;
    w.dst     = d;
    w.jmp     = JMP_NEXT;
    w.target  = '0;
    w.cnt_inc = 1'b0;
    return w;
  endfunction

  // Microcode program: one RK4 step. k1 lands in S, 2*k2 and 2*k3 in V.
  function automatic ucode_t ucode_word(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = uword(MUL_NONE, SRC_X, SRC_X, ALU_NOP, SRC_X, SRC_X, DST_NONE);
    case (int'(upc))
      0: begin
        w.jmp    = JMP_IF_DONE;
        w.target = UPC_FIN;
      end
      1:  w = uword(MUL_PROD, SRC_Y, SRC_Y, ALU_HALF, SRC_H, SRC_H, DST_XM);
      2:  w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      3:  w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_X, SRC_XM, DST_XM);
      4:  w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_ONE, SRC_X, DST_U);
      5:  w = uword(MUL_PROD, SRC_U, SRC_T, ALU_ADD, SRC_X, SRC_H, DST_XB);
      6:  w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      7:  w = uword(MUL_NONE, SRC_X, SRC_X, ALU_HALF, SRC_T, SRC_T, DST_S);
      8:  w = uword(MUL_PROD, SRC_H, SRC_S, ALU_NOP, SRC_X, SRC_X, DST_NONE);
      9:  w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      10: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_HALF, SRC_T, SRC_T, DST_T);
      11: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_Y, SRC_T, DST_T);
      12: w = uword(MUL_PROD, SRC_T, SRC_T, ALU_ADD, SRC_ONE, SRC_XM, DST_U);
      13: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      14: w = uword(MUL_PROD, SRC_U, SRC_T, ALU_NOP, SRC_X, SRC_X, DST_NONE);
      15: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      16: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_HALF, SRC_T, SRC_T, DST_K);
      17: w = uword(MUL_PROD, SRC_H, SRC_K, ALU_ADD, SRC_K, SRC_K, DST_V);
      18: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      19: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_HALF, SRC_T, SRC_T, DST_T);
      20: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_Y, SRC_T, DST_T);
      21: w = uword(MUL_PROD, SRC_T, SRC_T, ALU_ADD, SRC_ONE, SRC_XM, DST_U);
      22: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      23: w = uword(MUL_PROD, SRC_U, SRC_T, ALU_ADD, SRC_S, SRC_V, DST_S);
      24: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      25: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_HALF, SRC_T, SRC_T, DST_K);
      26: w = uword(MUL_PROD, SRC_H, SRC_K, ALU_ADD, SRC_K, SRC_K, DST_V);
      27: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      28: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_Y, SRC_T, DST_T);
      29: w = uword(MUL_PROD, SRC_T, SRC_T, ALU_ADD, SRC_ONE, SRC_XB, DST_U);
      30: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      31: w = uword(MUL_PROD, SRC_U, SRC_T, ALU_NOP, SRC_X, SRC_X, DST_NONE);
      32: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      33: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_HALF, SRC_T, SRC_T, DST_K);
      34: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_V, SRC_K, DST_V);
      35: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_S, SRC_V, DST_S);
      36: w = uword(MUL_PROD, SRC_S, SRC_H, ALU_NOP, SRC_X, SRC_X, DST_NONE);
      37: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_MULQ, SRC_X, SRC_X, DST_T);
      38: w = uword(MUL_DIV6, SRC_T, SRC_T, ALU_NOP, SRC_X, SRC_X, DST_NONE);
      39: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_DIV6, SRC_X, SRC_X, DST_T);
      40: w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_Y, SRC_T, DST_Y);
      41: begin
        w = uword(MUL_NONE, SRC_X, SRC_X, ALU_ADD, SRC_X, SRC_H, DST_X);
        w.cnt_inc = 1'b1;
      end
      default: w.jmp = JMP_FINISH;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rk4_ode_step_unit.sv
// Stepping item: runs the microcode program from accept to result valid; held
// item (count reached): jumps to the finish word. No new item is taken until then.
// The pace is set by the single shared 32x32 multiplier and the one ALU operation
// per microcode word (43-word program, one word per cycle unless held at finish).
// Synchronous active-high reset: loads register defaults and the start point.
// Depends on rk4_pkg.
module rk4_ode_step_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [rk4_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rk4_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                restart,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rk4_pkg::CNT_WIDTH-1:0]       step_index,
  output rk4_pkg::fix_t                       x_value,
  output rk4_pkg::fix_t                       y_value,
  output logic                                last_step,
  output logic                                overflow
);
  import rk4_pkg::*;

  localparam int DW = DATA_WIDTH;

  // Configuration registers. They reach the state only through a restart,
  // except step size and count, which are read live during a step.
  fix_t                 x_start;
  fix_t                 y_start;
  fix_t                 step_size;
  logic [CNT_WIDTH-1:0] step_count;

  // Integrator state.
  fix_t                 x_now;
  fix_t                 y_now;
  logic [CNT_WIDTH-1:0] steps_done;
  logic                 sat;

  // Working registers: midpoint x, end x, temporaries, slope, sum halves.
  fix_t xm, xb, t, u, k, s, v;

  // Shared multiplier: magnitude product and sign of the result.
  logic [2*DW-1:0] prod;
  logic            psign;

  // Sequencer.
  seq_state_t       state, state_next;
  logic [UPC_W-1:0] upc, upc_next;
  ucode_t           uw;
  logic             run;
  logic             done;
  logic             in_accept;
  logic             fin_fire;

  // Datapath signals.
  bank_t                 bank;
  fix_t                  mul_a, mul_b;
  mag_t                  mpa, mpb;
  logic                  mneg;
  fix_t                  alu_a, alu_b;
  logic [DW:0]           add_sum;
  logic                  add_sat;
  logic [DW:0]           half_inc;
  logic [2*DW:0]         rnd;
  logic [MAG_W-1:0]      rnd_mag;
  logic                  mulq_sat;
  logic [DIV6_Q_W-1:0]   div_q;
  fix_t                  alu_res;
  logic                  alu_sat;

  assign uw   = ucode_word(upc);
  assign run  = (state == SEQ_RUN);
  assign done = (steps_done >= step_count);

  // ---------------------------------------------------------------------
  // Sequencer next state: dispatch, conditional jump to the finish word
  // when the count is already reached, and hold at finish while the
  // output register is still occupied and stalled.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    upc_next   = upc;
    case (state)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_next = SEQ_RUN;
          upc_next   = '0;
        end
      end
      SEQ_RUN: begin
        case (uw.jmp)
          JMP_NEXT:    upc_next = upc + UPC_W'(1);
          JMP_IF_DONE: upc_next = done ? uw.target : upc + UPC_W'(1);
          JMP_FINISH: begin
            if (!(out_valid && out_stall)) begin
              state_next = SEQ_IDLE;
            end
          end
          default:     upc_next = upc;
        endcase
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: take an item only while idle; deliver at finish.
  always_comb begin
    in_stall  = rst || (state != SEQ_IDLE);
    in_accept = in_valid && !in_stall;
    fin_fire  = run && (uw.jmp == JMP_FINISH) && !(out_valid && out_stall);
  end

  // ---------------------------------------------------------------------
  // Operand muxes and the multiplier input stage. A divide-by-six pass
  // multiplies (|a| + 3) by the reciprocal; the quotient is the top bits.
  // ---------------------------------------------------------------------
  always_comb begin
    bank = '{x: x_now, y: y_now, h: step_size, xm: xm, xb: xb,
             t: t, u: u, k: k, s: s, v: v};
    mul_a = pick(bank, uw.mul_a);
    mul_b = pick(bank, uw.mul_b);
    alu_a = pick(bank, uw.alu_a);
    alu_b = pick(bank, uw.alu_b);
    mpa   = mag_of(mul_a);
    mpb   = mag_of(mul_b);
    mneg  = mul_a[DW-1] ^ mul_b[DW-1];
    if (uw.mul_op == MUL_DIV6) begin
      mpa  = mag_of(mul_a) + mag_t'(3);
      mpb  = DIV6_RECIP;
      mneg = mul_a[DW-1];
    end
  end

  // ---------------------------------------------------------------------
  // ALU: saturating add, rounded halving, rounded product with saturation
  // (ties away from zero on the magnitude), and the divide-by-six result.
  // ---------------------------------------------------------------------
  always_comb begin
    add_sum  = {alu_a[DW-1], alu_a} + {alu_b[DW-1], alu_b};
    add_sat  = add_sum[DW] ^ add_sum[DW-1];
    half_inc = {1'b0, mag_of(alu_a)} + (DW+1)'(1);
    rnd      = {1'b0, prod} + ((2*DW+1)'(1) << (FRAC_BITS - 1));
    rnd_mag  = rnd[2*DW:FRAC_BITS];
    mulq_sat = psign ? (rnd_mag > MAG_LIM_NEG) : (rnd_mag > MAG_LIM_POS);
    div_q    = prod[2*DW-1:DIV6_SHIFT];
    alu_res  = '0;
    alu_sat  = 1'b0;
    case (uw.alu_op)
      ALU_ADD: begin
        alu_sat = add_sat;
        alu_res = add_sat ? (add_sum[DW] ? FIX_MIN : FIX_MAX) : fix_t'(add_sum[DW-1:0]);
      end
      ALU_HALF: begin
        alu_res = neg_if(alu_a[DW-1], half_inc[DW:1]);
      end
      ALU_MULQ: begin
        alu_sat = mulq_sat;
        alu_res = mulq_sat ? (psign ? FIX_MIN : FIX_MAX) : neg_if(psign, rnd_mag[DW-1:0]);
      end
      ALU_DIV6: begin
        alu_res = neg_if(psign, mag_t'(div_q));
      end
      default: alu_res = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control, configuration and integrator state.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      upc        <= '0;
      out_valid  <= 1'b0;
      x_start    <= X_START_RST;
      y_start    <= Y_START_RST;
      step_size  <= STEP_SIZE_RST;
      step_count <= STEP_COUNT_RST;
      x_now      <= X_START_RST;
      y_now      <= Y_START_RST;
      steps_done <= '0;
      sat        <= 1'b0;
    end else begin
      state     <= state_next;
      upc       <= upc_next;
      // hold a result until taken; a new one may replace it on the same edge
      out_valid <= fin_fire || (out_valid && out_stall);

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_X_START:    x_start    <= fix_t'(cfg_data);
          REG_Y_START:    y_start    <= fix_t'(cfg_data);
          REG_STEP_SIZE:  step_size  <= fix_t'(cfg_data);
          REG_STEP_COUNT: step_count <= cfg_data[CNT_WIDTH-1:0];
          default: ;
        endcase
      end

      if (in_accept) begin
        // clear the per-step overflow flag; reload the start point on restart
        sat <= 1'b0;
        if (restart) begin
          x_now      <= x_start;
          y_now      <= y_start;
          steps_done <= '0;
        end
      end else if (run) begin
        sat <= sat | alu_sat;
        if (uw.dst == DST_X) x_now <= alu_res;
        if (uw.dst == DST_Y) y_now <= alu_res;
        if (uw.cnt_inc) steps_done <= steps_done + CNT_WIDTH'(1);
      end
    end
  end

  // Working registers and the product register.
  always_ff @(posedge clk) begin
    if (run) begin
      if (uw.mul_op != MUL_NONE) begin
        prod  <= (2*DW)'(mpa) * (2*DW)'(mpb);
        psign <= mneg;
      end
      case (uw.dst)
        DST_XM:  xm <= alu_res;
        DST_XB:  xb <= alu_res;
        DST_T:   t  <= alu_res;
        DST_U:   u  <= alu_res;
        DST_K:   k  <= alu_res;
        DST_S:   s  <= alu_res;
        DST_V:   v  <= alu_res;
        default: ;
      endcase
    end
  end

  // Output register: capture the finished state at the finish word.
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      step_index <= steps_done;
      x_value    <= x_now;
      y_value    <= y_now;
      last_step  <= done;
      overflow   <= sat;
    end
  end

endmodule

>>> hw/rtl/rk4_chk.sv
// Port-level checker for the RK4 step unit, bound to its top level.
// Depends on rk4_pkg and rk4_ode_step_unit_macros.svh.
`include "rk4_ode_step_unit_macros.svh"

module rk4_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rk4_pkg::CNT_WIDTH-1:0]   step_index,
  input rk4_pkg::fix_t                   x_value,
  input rk4_pkg::fix_t                   y_value
);

  logic out_held;

  assign out_held = out_valid && out_stall;

  // a stalled result holds its payload
  `RK4_ASSERT_NXT(a_out_hold, clk, rst, out_held, out_valid && $stable(step_index))
  `RK4_ASSERT_NXT(a_point_hold, clk, rst, out_held, $stable(x_value) && $stable(y_value))

  // an accepted item keeps the unit busy for at least the next cycle
  `RK4_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)

  // a new result only appears out of work in progress
  `RK4_ASSERT_IMP(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind rk4_ode_step_unit rk4_chk u_rk4_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .step_index (step_index),
  .x_value    (x_value),
  .y_value    (y_value)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for rk4_ode_step_unit: a directed table, then random phases under
// sender idling, receiver stalls and a long output hold-off, checked by a Q8.24 RK4 predictor.
// Depends on rk4_pkg and the rk4_ode_step_unit RTL; reads no files.
module testbench;
  import rk4_pkg::*;

  // Cycles with no item moving on either side before the run is declared hung.
  // The slowest legal stretch is the output hold-off plus one full step.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 106;

  localparam longint SAT_HI = longint'(FIX_MAX);
  localparam longint SAT_LO = longint'(FIX_MIN);

  // One result item of the block, in port order.
  typedef struct packed {
    logic [CNT_WIDTH-1:0] idx;
    fix_t                 x;
    fix_t                 y;
    logic                 last;
    logic                 ovf;
  } point_t;

  // One row of the directed table: either a register write or an input item.
  // Rows with typed set carry their result; the others go through the predictor.
  typedef struct {
    bit                    is_write;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] wdata;
    bit                    rs;
    bit                    typed;
    point_t                pt;
  } row_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   restart    = 1'b0;
  logic                   out_stall  = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [CNT_WIDTH-1:0]   step_index;
  fix_t                   x_value;
  fix_t                   y_value;
  logic                   last_step;
  logic                   overflow;

  // Typed result travels with the item it belongs to, so the monitor picks it
  // up at the same edge the item is accepted.
  logic                   stim_typed = 1'b0;
  point_t                 stim_point = '0;

  // Predictor copy of the registers and the integration state.
  longint      start_x, start_y, h_reg;
  int unsigned count_reg;
  longint      cur_x, cur_y;
  int unsigned done_steps;
  bit          clipped;

  point_t trajectory_q[$];
  row_t   plan[$];
  int     bad_count = 0;
  int     quiet = 0;

  // Idling knobs, set by the sequencer per phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;

  rk4_ode_step_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .step_index (step_index),
    .x_value    (x_value),
    .y_value    (y_value),
    .last_step  (last_step),
    .overflow   (overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the integrator. Every saturation sets clipped,
  // which becomes the overflow flag of the step.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned q_abs(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Rebuild a signed value from sign and magnitude, clamping to the 32-bit range.
  function automatic longint q_sat(input bit neg, input longint unsigned mag);
    if (!neg) begin
      if (mag > 64'(SAT_HI)) begin
        clipped = 1'b1;
        return SAT_HI;
      end
      return longint'(mag);
    end
    if (mag > 64'(SAT_HI) + 64'd1) begin
      clipped = 1'b1;
      return SAT_LO;
    end
    return -longint'(mag);
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    longint r;
    r = a + b;
    if (r > SAT_HI) begin
      clipped = 1'b1;
      return SAT_HI;
    end
    if (r < SAT_LO) begin
      clipped = 1'b1;
      return SAT_LO;
    end
    return r;
  endfunction

  // Product of two Q8.24 values, rounded half away from zero on the magnitude.
  function automatic longint q_mul(input longint a, input longint b);
    longint unsigned p;
    p = q_abs(a) * q_abs(b);
    p = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return q_sat((a < 0) != (b < 0), p);
  endfunction

  function automatic longint q_half(input longint v);
    return q_sat(v < 0, (q_abs(v) + 64'd1) >> 1);
  endfunction

  function automatic longint q_div6(input longint v);
    return q_sat(v < 0, (q_abs(v) + 64'd3) / 64'd6);
  endfunction

  // Right-hand side of the equation: 0.5 * (1 + x) * y^2.
  function automatic longint dydx(input longint x, input longint y);
    longint y2, t;
    y2 = q_mul(y, y);
    t  = q_add(longint'(FIX_ONE), x);
    return q_half(q_mul(t, y2));
  endfunction

  // Advance the integration state by one item and return the point it yields.
  function automatic point_t integrate_step(input logic rs);
    longint h, xm, k1, k2, k3, k4, s;
    point_t p;
    clipped = 1'b0;
    if (rs) begin
      cur_x      = start_x;
      cur_y      = start_y;
      done_steps = 0;
    end
    // Past the count (or with a count of zero) the state just holds.
    if (done_steps < count_reg) begin
      h  = h_reg;
      xm = q_add(cur_x, q_half(h));
      k1 = dydx(cur_x, cur_y);
      k2 = dydx(xm, q_add(cur_y, q_half(q_mul(h, k1))));
      k3 = dydx(xm, q_add(cur_y, q_half(q_mul(h, k2))));
      k4 = dydx(q_add(cur_x, h), q_add(cur_y, q_mul(h, k3)));
      s  = q_add(q_add(k1, q_add(k2, k2)), q_add(q_add(k3, k3), k4));
      cur_y      = q_add(cur_y, q_div6(q_mul(s, h)));
      cur_x      = q_add(cur_x, h);
      done_steps = (done_steps + 1) & 32'hFFFF;
    end
    p.idx  = CNT_WIDTH'(done_steps);
    p.x    = fix_t'(cur_x);
    p.y    = fix_t'(cur_y);
    p.last = (done_steps >= count_reg);
    p.ovf  = clipped;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on every accepted input item and
  // compare every accepted result item against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t got, want;
    if (rst) begin
      start_x    = longint'(X_START_RST);
      start_y    = longint'(Y_START_RST);
      h_reg      = longint'(STEP_SIZE_RST);
      count_reg  = STEP_COUNT_RST;
      cur_x      = start_x;
      cur_y      = start_y;
      done_steps = 0;
      trajectory_q.delete();
    end else begin
      // Start-point writes only reach the state at the next restart, so just latch them; step and count act live.
      if (cfg_we) begin
        case (cfg_index)
          REG_X_START:    start_x   = longint'(fix_t'(cfg_data));
          REG_Y_START:    start_y   = longint'(fix_t'(cfg_data));
          REG_STEP_SIZE:  h_reg     = longint'(fix_t'(cfg_data));
          REG_STEP_COUNT: count_reg = cfg_data[CNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = integrate_step(restart);
        if (stim_typed) want = stim_point;
        trajectory_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{step_index, x_value, y_value, last_step, overflow};
        if (trajectory_q.size() == 0) begin
          $error("result item with nothing pending: step_index %0d", got.idx);
          bad_count++;
        end else begin
          want = trajectory_q.pop_front();
          if (got.idx !== want.idx) begin
            $error("step_index: expected %0d, got %0d", want.idx, got.idx);
            bad_count++;
          end
          if (got.x !== want.x) begin
            $error("x_value: expected %0d, got %0d", want.x, got.x);
            bad_count++;
          end
          if (got.y !== want.y) begin
            $error("y_value: expected %0d, got %0d", want.y, got.y);
            bad_count++;
          end
          if (got.last !== want.last) begin
            $error("last_step: expected %0b, got %0b", want.last, got.last);
            bad_count++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
            bad_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when the sequencer asks for one.
  // The hold-off is counted here so the sender keeps pushing items meanwhile.
  always @(posedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("rk4_ode_step_unit: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item after gap idle cycles and hold it until accepted.
  // Returns at the edge that takes the item.
  task automatic put_item(input bit rs, input int gap, input bit typed, input point_t pt);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    restart    <= rs;
    stim_typed <= typed;
    stim_point <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted point has come out.
  // Sampled on the falling edge so the monitor has settled the queue.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (trajectory_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic cfg_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic plan_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    row_t r;
    r          = '{sel: REG_X_START, default: '0};
    r.is_write = 1'b1;
    r.sel      = sel;
    r.wdata    = d;
    plan.push_back(r);
  endtask

  task automatic plan_item(input bit rs);
    row_t r;
    r    = '{sel: REG_X_START, default: '0};
    r.rs = rs;
    plan.push_back(r);
  endtask

  task automatic plan_point(input bit rs, input int n, input fix_t x, input fix_t y,
                            input bit last, input bit ovf);
    row_t r;
    r       = '{sel: REG_X_START, default: '0};
    r.rs    = rs;
    r.typed = 1'b1;
    r.pt    = '{CNT_WIDTH'(n), x, y, last, ovf};
    plan.push_back(r);
  endtask

  // Mostly values in a realistic band of +/- 2^span, sometimes anything,
  // sometimes the range ends and the smallest steps.
  function automatic logic [CFG_DATA_W-1:0] rand_fix(input int span);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return CFG_DATA_W'(int'($urandom_range(2 ** (span + 1))) - 2 ** span);
    if (sel < 85) return CFG_DATA_W'($urandom);
    case ($urandom_range(4))
      0:       return FIX_MIN;
      1:       return FIX_MAX;
      2:       return '0;
      3:       return CFG_DATA_W'(1);
      default: return '1;
    endcase
  endfunction

  // New start point, step and count for a random phase; the count is returned
  // so the sequencer knows when a run has gone past its end.
  task automatic random_setup(output int n);
    int unsigned sel;
    cfg_write(REG_X_START, rand_fix(25));
    cfg_write(REG_Y_START, rand_fix(24));
    cfg_write(REG_STEP_SIZE, rand_fix(22));
    sel = $urandom_range(99);
    if (sel < 80)      n = $urandom_range(24, 1);
    else if (sel < 90) n = 0;
    else if (sel < 95) n = 65535;
    else               n = $urandom_range(65535);
    // Upper data bits are don't-care for the count; toggle them anyway.
    cfg_write(REG_STEP_COUNT, {16'($urandom), 16'(n)});
  endtask

  initial begin
    int     gap, run_len, cur_count, mode;
    bit     rs;
    point_t none;
    int     idle_tab[4];
    int     stall_tab[4];
    none      = '0;
    idle_tab  = '{0, 63, 0, 19};
    stall_tab = '{0, 0, 63, 19};

    // Directed table. Defaults after reset: x0 = 0, y0 = 1.0, h ~ 0.1, 10 steps.
    plan_item(1'b0);                               // first steps straight out of reset
    plan_item(1'b0);
    plan_write(REG_STEP_COUNT, 32'hFFFF_0000);     // count zero, junk upper bits
    plan_point(1'b1, 0, fix_t'(0), FIX_ONE, 1'b1, 1'b0);
    plan_point(1'b0, 0, fix_t'(0), FIX_ONE, 1'b1, 1'b0);
    plan_write(REG_X_START, FIX_MAX);
    plan_write(REG_Y_START, FIX_MIN);
    plan_point(1'b1, 0, FIX_MAX, FIX_MIN, 1'b1, 1'b0);
    plan_write(REG_STEP_COUNT, 32'd1);             // one step from extreme start
    plan_item(1'b1);
    plan_item(1'b0);                               // past the count: hold
    plan_write(REG_X_START, FIX_MIN);
    plan_write(REG_Y_START, FIX_MAX);
    plan_write(REG_STEP_SIZE, FIX_MIN);
    plan_item(1'b1);
    // Flat solution: y stays zero, h zero keeps x put.
    plan_write(REG_X_START, 32'd0);
    plan_write(REG_Y_START, 32'd0);
    plan_write(REG_STEP_SIZE, 32'd0);
    plan_write(REG_STEP_COUNT, 32'd3);
    plan_point(1'b1, 1, fix_t'(0), fix_t'(0), 1'b0, 1'b0);
    plan_point(1'b0, 2, fix_t'(0), fix_t'(0), 1'b0, 1'b0);
    plan_point(1'b0, 3, fix_t'(0), fix_t'(0), 1'b1, 1'b0);
    plan_point(1'b0, 3, fix_t'(0), fix_t'(0), 1'b1, 1'b0);
    // Unit step on the flat solution: x walks 1.0, 2.0.
    plan_write(REG_STEP_SIZE, FIX_ONE);
    plan_write(REG_STEP_COUNT, 32'd2);
    plan_point(1'b1, 1, FIX_ONE, fix_t'(0), 1'b0, 1'b0);
    plan_point(1'b0, 2, fix_t'(2 * FIX_ONE), fix_t'(0), 1'b1, 1'b0);
    // x at the top plus the largest step: x saturates, flag raised.
    plan_write(REG_X_START, FIX_MAX);
    plan_write(REG_STEP_SIZE, FIX_MAX);
    plan_write(REG_STEP_COUNT, 32'd1);
    plan_point(1'b1, 1, FIX_MAX, fix_t'(0), 1'b1, 1'b0 | 1'b1);
    // Back to the default problem with the longest count.
    plan_write(REG_X_START, X_START_RST);
    plan_write(REG_Y_START, Y_START_RST);
    plan_write(REG_STEP_SIZE, STEP_SIZE_RST);
    plan_write(REG_STEP_COUNT, 32'hABCD_FFFF);
    plan_item(1'b1);
    plan_item(1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) cfg_write(plan[i].sel, plan[i].wdata);
      else put_item(plan[i].rs, 0, plan[i].typed, plan[i].pt);
    end

    // Random phases: each one drains, reprograms, picks an idling mode and
    // runs restart-led trajectories, with the occasional stray restart.
    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup(cur_count);
      mode           = ph % 4;
      send_idle_pct  = idle_tab[mode];
      recv_stall_pct = stall_tab[mode];
      run_len        = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Starve the output while the sender keeps offering, to back the block up.
        if (ph == 4 && k == 30) hold_ask++;
        rs = (k == 0) || (run_len >= cur_count + $urandom_range(3))
             || ($urandom_range(99) < 3);
        run_len = rs ? 1 : run_len + 1;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
        put_item(rs, gap, 1'b0, none);
        // Now and then let the block run completely dry mid-phase.
        if ($urandom_range(99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (bad_count == 0) $display("rk4_ode_step_unit: match");
    else $display("rk4_ode_step_unit: mismatch");
    $finish;
  end

endmodule

>>> rk4_ode_step_unit.f
+incdir+hw/rtl
hw/rtl/rk4_pkg.sv
hw/rtl/rk4_ode_step_unit.sv
hw/rtl/rk4_chk.sv
tb/sv/testbench.sv
